// File: rtl/ofip_pkg.sv
// Shared character codes and field codes for the OBJ face index parser.
package ofip_pkg;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_F     = 8'h66;

  // Which index of a corner group the digits belong to
  typedef enum logic [1:0] {
    FLD_VERT = 2'd0,
    FLD_TEX  = 2'd1,
    FLD_NORM = 2'd2,
    FLD_DROP = 2'd3
  } field_t;

endpackage

// File: rtl/obj_face_index_parser_core.sv
// OBJ face index parser: top level, byte-wide text in, one corner group per result word out.
//
// Takes OBJ text one byte per word on the input channel and returns the
// corner groups of face lines ("f" lines) on the output channel. Each group
// (v, v/t, v//n or v/t/n, each index optionally negative) comes out once
// the next group starts, or at the newline with last_corner set; absent
// indices read as 0 and magnitudes saturate at 2^(INDEX_BITS-1)-1. The
// corner number counts from 1 within a face and saturates at MAX_CORNERS
// (only its low 8 bits reach the port); the face number counts face lines
// from 1 since reset and saturates at all ones. Non-face lines, and stray
// bytes within a face line, produce nothing. Throughput is one byte per
// clock unless the output stalls: the parser state updates in the cycle a
// word is accepted, and a resulting word sits in the output register from
// the next cycle. That output register is the only stall point: input is
// taken whenever the register is empty or being drained in the same cycle.
// Worst path is the multiply-by-ten-plus-digit and saturate compare on the accumulator.
module obj_face_index_parser_core #(
  parameter int INDEX_BITS      = 24,
  parameter int MAX_CORNERS     = 255,
  parameter int FACE_COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        char_code,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [INDEX_BITS-1:0]      vertex_index,
  output logic signed [INDEX_BITS-1:0]      texture_index,
  output logic signed [INDEX_BITS-1:0]      normal_index,
  output logic [7:0]                        corner_number,
  output logic [FACE_COUNT_BITS-1:0]        face_number,
  output logic                              last_corner
);

  localparam int MagBits    = INDEX_BITS - 1;
  // at least 8 bits so the port slice always exists
  localparam int CornerBits = ($clog2(MAX_CORNERS + 1) > 8) ? $clog2(MAX_CORNERS + 1) : 8;
  localparam logic [CornerBits-1:0] CornerMax = CornerBits'(MAX_CORNERS);

  typedef enum logic [1:0] {
    PH_START = 2'd0,  // at start of line
    PH_FACE  = 2'd1,  // inside a face line
    PH_SKIP  = 2'd2   // rest of line ignored
  } phase_t;

  // Signed value of a finished field
  function automatic logic [INDEX_BITS-1:0] field_value(input logic [MagBits-1:0] mag,
                                                       input logic neg);
    logic [INDEX_BITS-1:0] ext;
    ext = {1'b0, mag};
    return neg ? (~ext + 1'b1) : ext;
  endfunction

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_t                       phase, phase_next;
  ofip_pkg::field_t             field, field_next;
  logic                         neg, neg_next;
  logic [MagBits-1:0]           acc, acc_next;
  logic [INDEX_BITS-1:0]        pend_v, pend_v_next;
  logic [INDEX_BITS-1:0]        pend_t, pend_t_next;
  logic [INDEX_BITS-1:0]        pend_n, pend_n_next;
  logic                         pend_ok, pend_ok_next;
  logic                         in_grp, in_grp_next;
  logic [CornerBits-1:0]        corner_cnt, corner_cnt_next;
  logic [FACE_COUNT_BITS-1:0]   face_cnt, face_cnt_next;

  // result of this word
  logic                         emit;
  logic                         emit_last;
  logic [INDEX_BITS-1:0]        emit_v, emit_t, emit_n;

  logic                         in_fire;
  logic                         digit_ch;
  logic                         is_sep;
  logic [MagBits+3:0]           prod;
  logic [MagBits-1:0]           acc_dig;
  logic [INDEX_BITS-1:0]        cval;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign digit_ch = (char_code >= ofip_pkg::CH_ZERO) && (char_code <= ofip_pkg::CH_NINE);
  assign is_sep   = (char_code == ofip_pkg::CH_SPACE) || (char_code == ofip_pkg::CH_TAB) ||
                    (char_code == ofip_pkg::CH_CR);

  // acc*10 + digit, saturating; low nibble of '0'..'9' is the digit value
  assign prod    = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) +
                   {{MagBits{1'b0}}, char_code[3:0]};
  assign acc_dig = (prod > {4'b0, {MagBits{1'b1}}}) ? {MagBits{1'b1}} : prod[MagBits-1:0];

  // value of the field being read (outside a group acc and neg are zero)
  assign cval = field_value(acc, neg);

  always_comb begin
    phase_next      = phase;
    field_next      = field;
    neg_next        = neg;
    acc_next        = acc;
    pend_v_next     = pend_v;
    pend_t_next     = pend_t;
    pend_n_next     = pend_n;
    pend_ok_next    = pend_ok;
    in_grp_next     = in_grp;
    corner_cnt_next = corner_cnt;
    face_cnt_next   = face_cnt;
    emit            = 1'b0;
    emit_last       = 1'b0;
    emit_v          = pend_v;
    emit_t          = pend_t;
    emit_n          = pend_n;

    unique case (phase)
      PH_START: begin
        if (char_code == ofip_pkg::CH_F) begin
          phase_next = PH_FACE;
          if (face_cnt != {FACE_COUNT_BITS{1'b1}}) begin
            face_cnt_next = face_cnt + 1'b1;
          end
        end else if (char_code != ofip_pkg::CH_NL) begin
          phase_next = PH_SKIP;
        end
      end

      PH_FACE: begin
        if (char_code == ofip_pkg::CH_NL) begin
          // close the line; a group still open is finished first
          if (in_grp) begin
            emit = 1'b1;
            unique case (field)
              ofip_pkg::FLD_VERT: emit_v = cval;
              ofip_pkg::FLD_TEX:  emit_t = cval;
              ofip_pkg::FLD_NORM: emit_n = cval;
              default:            ;
            endcase
          end else if (pend_ok) begin
            emit = 1'b1;
          end
          emit_last       = 1'b1;
          field_next      = ofip_pkg::FLD_VERT;
          neg_next        = 1'b0;
          acc_next        = '0;
          pend_v_next     = '0;
          pend_t_next     = '0;
          pend_n_next     = '0;
          pend_ok_next    = 1'b0;
          in_grp_next     = 1'b0;
          corner_cnt_next = '0;
          phase_next      = PH_START;
        end else if (is_sep) begin
          if (in_grp) begin
            unique case (field)
              ofip_pkg::FLD_VERT: pend_v_next = cval;
              ofip_pkg::FLD_TEX:  pend_t_next = cval;
              ofip_pkg::FLD_NORM: pend_n_next = cval;
              default:            ;
            endcase
            acc_next     = '0;
            neg_next     = 1'b0;
            in_grp_next  = 1'b0;
            pend_ok_next = 1'b1;
          end
        end else if (digit_ch || char_code == ofip_pkg::CH_MINUS ||
                     char_code == ofip_pkg::CH_SLASH) begin
          // digit, minus or slash; with no group open a group starts: the held one goes out, a fresh one begins
          if (!in_grp) begin
            emit         = pend_ok;
            field_next   = ofip_pkg::FLD_VERT;
            pend_v_next  = '0;
            pend_t_next  = '0;
            pend_n_next  = '0;
            pend_ok_next = 1'b0;
            in_grp_next  = 1'b1;
            if (corner_cnt != CornerMax) begin
              corner_cnt_next = corner_cnt + 1'b1;
            end
          end
          if (char_code == ofip_pkg::CH_SLASH) begin
            unique case (field_next)
              ofip_pkg::FLD_VERT: begin
                pend_v_next = cval;
                field_next  = ofip_pkg::FLD_TEX;
              end
              ofip_pkg::FLD_TEX: begin
                pend_t_next = cval;
                field_next  = ofip_pkg::FLD_NORM;
              end
              ofip_pkg::FLD_NORM: begin
                pend_n_next = cval;
                field_next  = ofip_pkg::FLD_DROP;
              end
              default: field_next = ofip_pkg::FLD_DROP;
            endcase
            acc_next = '0;
            neg_next = 1'b0;
          end else if (char_code == ofip_pkg::CH_MINUS) begin
            if (!neg && acc == '0) begin
              neg_next = 1'b1;
            end
          end else if (field_next != ofip_pkg::FLD_DROP) begin
            acc_next = acc_dig;
          end
        end
      end

      default: begin
        // ignored line, and the unused phase code behaves the same
        if (char_code == ofip_pkg::CH_NL) begin
          phase_next = PH_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      field      <= ofip_pkg::FLD_VERT;
      neg        <= 1'b0;
      acc        <= '0;
      pend_v     <= '0;
      pend_t     <= '0;
      pend_n     <= '0;
      pend_ok    <= 1'b0;
      in_grp     <= 1'b0;
      corner_cnt <= '0;
      face_cnt   <= '0;
    end else if (in_fire) begin
      phase      <= phase_next;
      field      <= field_next;
      neg        <= neg_next;
      acc        <= acc_next;
      pend_v     <= pend_v_next;
      pend_t     <= pend_t_next;
      pend_n     <= pend_n_next;
      pend_ok    <= pend_ok_next;
      in_grp     <= in_grp_next;
      corner_cnt <= corner_cnt_next;
      face_cnt   <= face_cnt_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      vertex_index  <= emit_v;
      texture_index <= emit_t;
      normal_index  <= emit_n;
      corner_number <= corner_cnt[7:0];
      face_number   <= face_cnt;
      last_corner   <= emit_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_emit_has_corner: assert property (@(posedge clk) disable iff (rst)
    (in_fire && emit) |-> (corner_cnt != '0))
    else $error("corner emitted with zero corner count");

  a_face_counted: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FACE) |-> (face_cnt != '0))
    else $error("face line active with zero face count");

  a_group_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_grp && pend_ok))
    else $error("open group and held group at once");

  a_nl_closes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && char_code == ofip_pkg::CH_NL) |=>
      (phase == PH_START && corner_cnt == '0 && !in_grp && !pend_ok))
    else $error("newline did not close the line");

endmodule
